// ----- sv/clc_pkg.sv -----
// Package for the current-loop 2P2Z compensator: item types, register
// indexes, clamp constants and the back-end state type.
// No dependencies.
package clc_pkg;

    localparam int ACC_W = 36;

    localparam logic [2:0] REG_GAIN_OUT1     = 3'd0;
    localparam logic [2:0] REG_GAIN_OUT2     = 3'd1;
    localparam logic [2:0] REG_GAIN_ERR0     = 3'd2;
    localparam logic [2:0] REG_GAIN_ERR1     = 3'd3;
    localparam logic [2:0] REG_GAIN_ERR2     = 3'd4;
    localparam logic [2:0] REG_TARGET_OFFSET = 3'd5;

    localparam logic [15:0] TARGET_HYST = 16'd100;
    localparam logic [15:0] CEIL_LIMIT  = 16'd80;
    localparam logic [15:0] CEIL_NORMAL = 16'd160;
    localparam logic [15:0] OUT_FLOOR   = 16'd50;

    typedef struct packed {
        logic [15:0] gain_out1;
        logic [15:0] gain_out2;
        logic [15:0] gain_err0;
        logic [15:0] gain_err1;
        logic [15:0] gain_err2;
    } gains_t;

    typedef struct packed {
        logic [15:0]       err0;
        logic [14:0]       voltage_target;
        logic signed [8:0] load_trim;
        logic              target_source;
    } work_t;

    typedef struct packed {
        logic [15:0] loop_output;
        logic [15:0] voltage_loop_ref;
        logic        in_current_limit;
        logic        target_source;
    } result_t;

    typedef enum logic [1:0] {
        ST_OUT_TERMS,
        ST_ERR_TERMS,
        ST_LAST_TERM,
        ST_FINISH
    } back_state_t;

endpackage

// ----- sv/clc_fifo.sv -----
// Two-entry queue used between front and back end and at the result side.
// No dependencies.
module clc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_next;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/clc_front.sv -----
// Front end: accepts items, selects the current target and forms the error.
// Depends on clc_pkg.
module clc_front (
    input  logic              push,
    output logic              full,
    input  logic [14:0]       current_sample,
    input  logic [14:0]       current_target,
    input  logic [14:0]       power_limit,
    input  logic [14:0]       voltage_target,
    input  logic signed [8:0] load_trim,
    input  logic [15:0]       target_offset,
    output logic              q_push,
    output clc_pkg::work_t    q_wdata,
    input  logic              q_full
);
    import clc_pkg::*;

    logic [15:0] cref_hyst;
    logic        use_plim;
    logic [14:0] target;

    always_comb
    begin
        cref_hyst = {1'b0, current_target} + TARGET_HYST;
        use_plim  = !(cref_hyst < {1'b0, power_limit});
        target    = use_plim ? power_limit : current_target;

        q_wdata.err0           = {1'b0, target} + target_offset - {1'b0, current_sample};
        q_wdata.voltage_target = voltage_target;
        q_wdata.load_trim      = load_trim;
        q_wdata.target_source  = use_plim;
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

// ----- sv/clc_back.sv -----
// Back end: 2P2Z multiply-accumulate on two shared multipliers, clamp,
// limit decision and loop history. Depends on clc_pkg.
module clc_back #(
    parameter int ACC_SHIFT = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  clc_pkg::gains_t   gains,
    input  clc_pkg::work_t    work,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              res_push,
    output clc_pkg::result_t  res,
    input  logic              res_full
);
    import clc_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [15:0] err_prev1_reg;
    logic [15:0] err_prev2_reg;
    logic [15:0] out_prev1_reg;
    logic [15:0] out_prev2_reg;
    logic        limit_flag_reg;

    logic signed [16:0] mul_a_x;
    logic signed [16:0] mul_a_g;
    logic signed [16:0] mul_b_x;
    logic signed [16:0] mul_b_g;
    logic signed [33:0] prod_a;
    logic signed [33:0] prod_b;
    logic signed [ACC_W-1:0] acc_base;

    logic [15:0]             ceil_val;
    logic signed [ACC_W-1:0] ceil_scaled;
    logic signed [ACC_W-1:0] floor_scaled;
    logic signed [ACC_W-1:0] acc_shifted;
    logic [15:0]             result;
    logic                    limit_now;
    logic [15:0]             trim16;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_OUT_TERMS:
            begin
                if (!q_empty)
                begin
                    state_next = ST_ERR_TERMS;
                end
            end
            ST_ERR_TERMS: state_next = ST_LAST_TERM;
            ST_LAST_TERM: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!res_full)
                begin
                    state_next = ST_OUT_TERMS;
                end
            end
            default: state_next = ST_OUT_TERMS;
        endcase
    end

    // Operand selection and handshakes; lane a adds, lane b subtracts
    always_comb
    begin
        mul_a_x  = '0;
        mul_a_g  = '0;
        mul_b_x  = '0;
        mul_b_g  = '0;
        acc_base = acc_reg;
        q_pop    = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            ST_OUT_TERMS:
            begin
                mul_a_x  = $signed({1'b0, out_prev1_reg});
                mul_a_g  = $signed({1'b0, gains.gain_out1});
                mul_b_x  = $signed({1'b0, out_prev2_reg});
                mul_b_g  = $signed({1'b0, gains.gain_out2});
                acc_base = '0;
            end
            ST_ERR_TERMS:
            begin
                mul_a_x = $signed({work.err0[15], work.err0});
                mul_a_g = $signed({1'b0, gains.gain_err0});
                mul_b_x = $signed({err_prev1_reg[15], err_prev1_reg});
                mul_b_g = $signed({1'b0, gains.gain_err1});
            end
            ST_LAST_TERM:
            begin
                mul_a_x = $signed({err_prev2_reg[15], err_prev2_reg});
                mul_a_g = $signed({1'b0, gains.gain_err2});
            end
            ST_FINISH:
            begin
                res_push = !res_full;
                q_pop    = !res_full;
            end
            default:
            begin
                acc_base = acc_reg;
            end
        endcase
    end

    assign prod_a   = mul_a_x * mul_a_g;
    assign prod_b   = mul_b_x * mul_b_g;
    assign acc_next = acc_base + ACC_W'(prod_a) - ACC_W'(prod_b);

    // Clamp and limit decision
    always_comb
    begin
        ceil_val     = {1'b0, work.voltage_target}
                     + (limit_flag_reg ? CEIL_LIMIT : CEIL_NORMAL);
        ceil_scaled  = $signed(ACC_W'(ceil_val) << ACC_SHIFT);
        floor_scaled = $signed(ACC_W'(OUT_FLOOR) << ACC_SHIFT);
        acc_shifted  = acc_reg >>> ACC_SHIFT;
        if (acc_reg >= ceil_scaled)
        begin
            result = ceil_val;
        end
        else if (acc_reg <= floor_scaled)
        begin
            result = OUT_FLOOR;
        end
        else
        begin
            result = acc_shifted[15:0];
        end
        limit_now = (result <= {1'b0, work.voltage_target});
        trim16    = 16'(work.load_trim);

        res.loop_output      = result;
        res.voltage_loop_ref = limit_now ? result
                                         : ({1'b0, work.voltage_target} + trim16);
        res.in_current_limit = limit_now;
        res.target_source    = work.target_source;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_OUT_TERMS;
            err_prev1_reg  <= '0;
            err_prev2_reg  <= '0;
            out_prev1_reg  <= '0;
            out_prev2_reg  <= '0;
            limit_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_push)
            begin
                err_prev2_reg  <= err_prev1_reg;
                err_prev1_reg  <= work.err0;
                out_prev2_reg  <= out_prev1_reg;
                out_prev1_reg  <= result;
                limit_flag_reg <= limit_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != ST_FINISH)
        begin
            acc_reg <= acc_next;
        end
    end

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_OUT_TERMS) |-> !q_empty)
        else $error("work item lost during compute");

    a_output_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res.loop_output >= OUT_FLOOR))
        else $error("output below floor");

    a_limit_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.in_current_limit) |-> (res.voltage_loop_ref == res.loop_output))
        else $error("limit reference mismatch");

    a_history_update: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (out_prev1_reg == $past(res.loop_output)))
        else $error("output history not updated");

endmodule

// ----- sv/current_loop_2p2z_compensator.sv -----
// The back end takes one item at a time through three multiply-accumulate steps on two shared
// 17x17 multipliers plus one clamp/finish step. It waits while the work queue is empty or the
// result queue is full, and takes no new item before the last one is through.
// Reset (rst_n low, asynchronous): queues empty, loop history, limit flag and
// all configuration registers cleared to zero.
// Top level: config registers, front end, work queue, back end, result queue.
module current_loop_2p2z_compensator #(
    parameter int ACC_SHIFT = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [14:0]       current_sample,
    input  logic [14:0]       current_target,
    input  logic [14:0]       power_limit,
    input  logic [14:0]       voltage_target,
    input  logic signed [8:0] load_trim,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       loop_output,
    output logic [15:0]       voltage_loop_ref,
    output logic              in_current_limit,
    output logic              target_source,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import clc_pkg::*;

    gains_t      gains_reg;
    logic [15:0] target_offset_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic    q_push;
    work_t   q_wdata;
    logic    q_full;
    work_t   q_rdata;
    logic    q_empty;
    logic    q_pop;
    logic    res_push;
    result_t res_wdata;
    logic    res_full;
    result_t res_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg         <= '0;
            target_offset_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_OUT1:     gains_reg.gain_out1 <= pwdata[15:0];
                REG_GAIN_OUT2:     gains_reg.gain_out2 <= pwdata[15:0];
                REG_GAIN_ERR0:     gains_reg.gain_err0 <= pwdata[15:0];
                REG_GAIN_ERR1:     gains_reg.gain_err1 <= pwdata[15:0];
                REG_GAIN_ERR2:     gains_reg.gain_err2 <= pwdata[15:0];
                REG_TARGET_OFFSET: target_offset_reg   <= pwdata[15:0];
                default:           gains_reg           <= gains_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_OUT1:     prdata = {16'd0, gains_reg.gain_out1};
            REG_GAIN_OUT2:     prdata = {16'd0, gains_reg.gain_out2};
            REG_GAIN_ERR0:     prdata = {16'd0, gains_reg.gain_err0};
            REG_GAIN_ERR1:     prdata = {16'd0, gains_reg.gain_err1};
            REG_GAIN_ERR2:     prdata = {16'd0, gains_reg.gain_err2};
            REG_TARGET_OFFSET: prdata = {16'd0, target_offset_reg};
            default:           prdata = '0;
        endcase
    end

    clc_front u_front (
        .push           (push),
        .full           (full),
        .current_sample (current_sample),
        .current_target (current_target),
        .power_limit    (power_limit),
        .voltage_target (voltage_target),
        .load_trim      (load_trim),
        .target_offset  (target_offset_reg),
        .q_push         (q_push),
        .q_wdata        (q_wdata),
        .q_full         (q_full)
    );

    clc_fifo #(
        .WIDTH ($bits(work_t))
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    clc_back #(
        .ACC_SHIFT (ACC_SHIFT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .gains    (gains_reg),
        .work     (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .res_push (res_push),
        .res      (res_wdata),
        .res_full (res_full)
    );

    clc_fifo #(
        .WIDTH ($bits(result_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign loop_output      = res_rdata.loop_output;
    assign voltage_loop_ref = res_rdata.voltage_loop_ref;
    assign in_current_limit = res_rdata.in_current_limit;
    assign target_source    = res_rdata.target_source;

endmodule

// ----- tb/loop_checker.sv -----
// Checker for the current-loop 2P2Z compensator: tracks register writes,
// predicts one result item per accepted input item and compares in order.
// Depends on clc_pkg.
module loop_checker #(
    parameter int ACC_SHIFT = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [14:0]       current_sample,
    input  logic [14:0]       current_target,
    input  logic [14:0]       power_limit,
    input  logic [14:0]       voltage_target,
    input  logic signed [8:0] load_trim,
    input  logic              empty,
    input  logic              pop,
    input  logic [15:0]       loop_output,
    input  logic [15:0]       voltage_loop_ref,
    input  logic              in_current_limit,
    input  logic              target_source,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                outstanding,
    output int                fail_count
);
    import clc_pkg::*;

    gains_t      gains;
    logic [15:0] offset;
    logic [15:0] err_hist1;
    logic [15:0] err_hist2;
    logic [15:0] out_hist1;
    logic [15:0] out_hist2;
    logic        limit_state;
    result_t     expected_ticks[$];
    result_t     want;
    int          mism = 0;

    function automatic result_t predict_tick(input logic [14:0] sample, input logic [14:0] cref,
                                             input logic [14:0] plim, input logic [14:0] vref,
                                             input logic signed [8:0] trim);
        logic [15:0] target;
        logic [15:0] err0;
        logic [15:0] ceil16;
        logic [15:0] res;
        longint      acc;
        longint      ceil_s;
        longint      floor_s;
        result_t     r;
        if ({1'b0, cref} + TARGET_HYST < {1'b0, plim})
        begin
            target = {1'b0, cref};
            r.target_source = 1'b0;
        end
        else
        begin
            target = {1'b0, plim};
            r.target_source = 1'b1;
        end
        err0 = target + offset - {1'b0, sample};
        acc = longint'(out_hist1) * longint'(gains.gain_out1)
            - longint'(out_hist2) * longint'(gains.gain_out2)
            + longint'($signed(err0)) * longint'(gains.gain_err0)
            - longint'($signed(err_hist1)) * longint'(gains.gain_err1)
            + longint'($signed(err_hist2)) * longint'(gains.gain_err2);
        ceil16 = {1'b0, vref} + (limit_state ? CEIL_LIMIT : CEIL_NORMAL);
        ceil_s = longint'(ceil16) << ACC_SHIFT;
        floor_s = longint'(OUT_FLOOR) << ACC_SHIFT;
        if (acc >= ceil_s)
            res = ceil16;
        else if (acc <= floor_s)
            res = OUT_FLOOR;
        else
            res = 16'(acc >>> ACC_SHIFT);
        err_hist2 = err_hist1;
        err_hist1 = err0;
        out_hist2 = out_hist1;
        out_hist1 = res;
        r.loop_output = res;
        if (res <= {1'b0, vref})
        begin
            r.voltage_loop_ref = res;
            limit_state = 1'b1;
        end
        else
        begin
            r.voltage_loop_ref = {1'b0, vref} + {{7{trim[8]}}, trim};
            limit_state = 1'b0;
        end
        r.in_current_limit = limit_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (got_val !== exp_val)
        begin
            mism++;
            if (mism <= 200)
                $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains       = '0;
            offset      = '0;
            err_hist1   = '0;
            err_hist2   = '0;
            out_hist1   = '0;
            out_hist2   = '0;
            limit_state = 1'b0;
            expected_ticks.delete();
            outstanding <= 0;
            fail_count  <= mism;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_GAIN_OUT1:     gains.gain_out1 = pwdata[15:0];
                    REG_GAIN_OUT2:     gains.gain_out2 = pwdata[15:0];
                    REG_GAIN_ERR0:     gains.gain_err0 = pwdata[15:0];
                    REG_GAIN_ERR1:     gains.gain_err1 = pwdata[15:0];
                    REG_GAIN_ERR2:     gains.gain_err2 = pwdata[15:0];
                    REG_TARGET_OFFSET: offset = pwdata[15:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (expected_ticks.size() == 0)
                begin
                    mism++;
                    if (mism <= 200)
                        $error("result item with nothing expected: loop_output %0d",
                               loop_output);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("loop_output", want.loop_output, loop_output);
                    check_field("voltage_loop_ref", want.voltage_loop_ref, voltage_loop_ref);
                    check_field("in_current_limit", 16'(want.in_current_limit),
                                16'(in_current_limit));
                    check_field("target_source", 16'(want.target_source), 16'(target_source));
                end
            end
            if (push && !full)
                expected_ticks.push_back(predict_tick(current_sample, current_target,
                                                      power_limit, voltage_target, load_trim));
            outstanding <= expected_ticks.size();
            fail_count  <= mism;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the compensator testbench: clock, reset, register writes and
// input/result stimulus; verdict from loop_checker.
// Depends on clc_pkg, current_loop_2p2z_compensator and loop_checker.
module testbench;
    import clc_pkg::*;

    localparam logic [2:0] NUM_REGS = 3'd6;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [14:0]       current_sample = '0;
    logic [14:0]       current_target = '0;
    logic [14:0]       power_limit = '0;
    logic [14:0]       voltage_target = '0;
    logic signed [8:0] load_trim = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [15:0]       loop_output;
    logic [15:0]       voltage_loop_ref;
    logic              in_current_limit;
    logic              target_source;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                outstanding;
    int                fail_count;
    logic              calm = 1'b0;

    current_loop_2p2z_compensator dut (.*);
    loop_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
        pop <= calm || ($urandom_range(99) >= 13);

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input gains_t g, input logic [15:0] offset);
        write_reg(REG_GAIN_OUT1, g.gain_out1);
        write_reg(REG_GAIN_OUT2, g.gain_out2);
        write_reg(REG_GAIN_ERR0, g.gain_err0);
        write_reg(REG_GAIN_ERR1, g.gain_err1);
        write_reg(REG_GAIN_ERR2, g.gain_err2);
        write_reg(REG_TARGET_OFFSET, offset);
        // writes past the register list must be dropped
        write_reg(NUM_REGS, 16'($urandom()));
        write_reg(NUM_REGS + 3'd1, 16'($urandom()));
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_item(input int s, input int c, input int p, input int v, input int t);
        push           <= 1'b1;
        current_sample <= 15'(s);
        current_target <= 15'(c);
        power_limit    <= 15'(p);
        voltage_target <= 15'(v);
        load_trim      <= 9'(t);
        do @(posedge clk); while (full);
        if (!calm && $urandom_range(99) < 13)
        begin
            push <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int s;
        int c;
        int p;
        int v;
        int tgt;
        c = $urandom_range(32767);
        p = $urandom_range(32767);
        v = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(32767);
        if ($urandom_range(99) < 75)
        begin
            // tracking tick: sample close to the selected target
            if ($urandom_range(3) == 0 && c + 100 <= 32767)
                p = c + 100;
            else if ($urandom_range(2) == 0)
                p = (c + $urandom_range(200) > 32767) ? 32767 : c + $urandom_range(200);
            tgt = (c + 100 < p) ? c : p;
            s = tgt + $urandom_range(600) - 300;
            if (s < 0)
                s = 0;
            if (s > 32760)
                s = 32760;
        end
        else
            s = $urandom_range(32760);
        send_item(s, c, p, v, $urandom_range(511));
    endtask

    function automatic gains_t plant_gains();
        gains_t g;
        g.gain_out1 = 16'($urandom_range(8192, 2048));
        g.gain_out2 = 16'($urandom_range(4096));
        g.gain_err0 = 16'($urandom_range(12288, 1024));
        g.gain_err1 = 16'($urandom_range(8192));
        g.gain_err2 = 16'($urandom_range(4096));
        return g;
    endfunction

    initial
    begin
        gains_t g;
        logic [15:0] offset;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset gains: output pinned at the floor
        send_item(0, 0, 0, 0, 0);
        send_item(32760, 32767, 32767, 32767, -256);
        settle();

        // unit error gain only: output follows the error
        g = '0;
        g.gain_err0 = 16'h1000;
        set_config(g, 16'h0000);
        send_item(0, 100, 200, 1000, 0);        // tie picks the power limit
        send_item(0, 99, 200, 1000, 0);
        send_item(0, 32767, 32767, 32767, 255);
        send_item(32760, 0, 32767, 100, -256);
        send_item(0, 5000, 32767, 20, -256);    // ceiling, trim wraps below zero
        send_item(0, 5000, 32767, 20, 255);
        send_item(0, 180, 32767, 20, 0);        // exactly at the ceiling
        send_item(0, 50, 32767, 0, 0);          // exactly at the floor
        send_item(0, 51, 32767, 100, 0);
        settle();

        // error wraps positive to negative and back
        set_config(g, 16'h7fff);
        send_item(0, 32767, 32767, 30000, 0);
        send_item(0, 32767, 32767, 30000, 0);
        settle();
        set_config(g, 16'h8000);
        send_item(32760, 0, 32767, 30000, 0);
        send_item(32760, 0, 32767, 30000, 0);
        settle();

        // history terms
        g = plant_gains();
        set_config(g, 16'h0000);
        send_item(100, 2000, 32767, 4000, 7);
        send_item(900, 2000, 32767, 4000, -7);
        send_item(2100, 2000, 32767, 4000, 0);
        send_item(2000, 2000, 32767, 4000, 0);

        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    g = '1;
                    offset = 16'h8000;
                end
                1:
                begin
                    g = '0;
                    offset = 16'h7fff;
                end
                4:
                begin
                    g = gains_t'({$urandom(), $urandom(), $urandom()});
                    offset = 16'($urandom());
                end
                default:
                begin
                    g = plant_gains();
                    offset = 16'($urandom_range(200) - 100);
                end
            endcase
            set_config(g, offset);
            calm = (phase == 2);
            repeat (190) send_random();
        end
        settle();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/clc_pkg.sv
sv/clc_fifo.sv
sv/clc_front.sv
sv/clc_back.sv
sv/current_loop_2p2z_compensator.sv
tb/loop_checker.sv
tb/testbench.sv
